// File: hdl/sdci_pkg.sv
// Package for the SD card bring-up sequencer.
// Holds the phase and action codes, response and fail codes, register indexes
// and the result item type. It has no dependencies.
package sdci_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD0,
    PH_CMD8,
    PH_CMD55,
    PH_ACMD41,
    PH_CMD2,
    PH_CMD3,
    PH_CLOCK,
    PH_CMD7,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    ACT_CMD   = 3'd0,
    ACT_RESET = 3'd1,
    ACT_CLOCK = 3'd2,
    ACT_DONE  = 3'd3,
    ACT_FAIL  = 3'd4
  } action_t;

  localparam logic KIND_START = 1'b0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CMD_ERR = 2'd1;

  localparam logic [1:0] FC_NONE        = 2'd0;
  localparam logic [1:0] FC_TIMEOUT     = 2'd1;
  localparam logic [1:0] FC_CMD_ERR     = 2'd2;
  localparam logic [1:0] FC_UNSUPPORTED = 2'd3;

  localparam logic [1:0] RT_NONE = 2'd0;
  localparam logic [1:0] RT_R48  = 2'd1;
  localparam logic [1:0] RT_R48B = 2'd2;
  localparam logic [1:0] RT_R136 = 2'd3;

  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
  localparam logic [5:0] CMD_SELECT      = 6'd7;
  localparam logic [5:0] CMD_SEND_IF     = 6'd8;
  localparam logic [5:0] CMD_SEND_OP     = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;

  localparam logic [2:0] REG_RETRY_LIMIT    = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_WINDOW = 3'd1;
  localparam logic [2:0] REG_CHECK_PATTERN  = 3'd2;
  localparam logic [2:0] REG_IDLE_PAUSE     = 3'd3;
  localparam logic [2:0] REG_RETRY_PAUSE    = 3'd4;

  localparam logic [15:0] RESET_RETRY_LIMIT    = 16'd1000;
  localparam logic [23:0] RESET_VOLTAGE_WINDOW = 24'hFF8000;
  localparam logic [7:0]  RESET_CHECK_PATTERN  = 8'hAA;
  localparam logic [19:0] RESET_IDLE_PAUSE     = 20'd2000;
  localparam logic [19:0] RESET_RETRY_PAUSE    = 20'd10000;

  localparam logic [3:0] CMD8_VHS = 4'h1;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    action_t     action;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  resp_type;
    logic        check_crc;
    logic        check_index;
    logic [19:0] pause_us;
    logic [1:0]  fail_code;
    logic [15:0] card_address;
    logic        high_capacity;
    logic        version_two;
    logic        last;
  } result_t;

  function automatic result_t make_result(action_t act, logic [5:0] cmd, logic [31:0] arg,
                                          logic [1:0] rt, logic crc, logic idx,
                                          logic [19:0] pause, logic [1:0] fail, logic lst);
    result_t r;
    r.action        = act;
    r.cmd_index     = cmd;
    r.argument      = arg;
    r.resp_type     = rt;
    r.check_crc     = crc;
    r.check_index   = idx;
    r.pause_us      = pause;
    r.fail_code     = fail;
    r.card_address  = 16'd0;
    r.high_capacity = 1'b0;
    r.version_two   = 1'b0;
    r.last          = lst;
    return r;
  endfunction

endpackage

// File: hdl/sd_card_init_sequencer_unit.sv
// Top level of the SD card bring-up sequencer: phase tracking, card state,
// configuration registers and a small output queue. Depends on sdci_pkg.
//
// Each accepted item is decoded in the cycle it is accepted, the card state is
// updated at that edge, and its results are written into a four-entry output
// queue, so the first result can be offered on the next cycle. The block takes
// one item per cycle while in_stall is low; an item gives one result, or two
// on a CMD8 command error, and none for an outcome arriving in the idle, done
// or fail phase. in_stall is high while fewer than two queue entries are free,
// so the rate is set only by how fast results are taken on the output side.
module sd_card_init_sequencer_unit
  import sdci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [1:0]  status,
  input  logic [31:0] response,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [5:0]  cmd_index,
  output logic [31:0] argument,
  output logic [1:0]  resp_type,
  output logic        check_crc,
  output logic        check_index,
  output logic [19:0] pause_us,
  output logic [1:0]  fail_code,
  output logic [15:0] card_address,
  output logic        high_capacity,
  output logic        version_two,
  output logic        last
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(QUEUE_DEPTH - 2);

  logic [15:0] retry_limit;
  logic [23:0] voltage_window;
  logic [7:0]  check_pattern;
  logic [19:0] idle_pause_us;
  logic [19:0] retry_pause_us;

  phase_t      phase, phase_next;
  logic        is_v2, is_v2_next;
  logic        is_high_cap, is_high_cap_next;
  logic [15:0] rel_addr, rel_addr_next;
  logic [15:0] attempts, attempts_next;
  logic [15:0] attempts_inc;

  result_t          queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  logic       accept, pop, ok;
  logic [1:0] fail_status;
  logic [1:0] n_res, push_n;
  result_t    res_a, res_b, res_a_raw, res_b_raw;

  assign accept       = in_valid && !in_stall;
  assign ok           = (status == ST_OK);
  assign fail_status  = (status == ST_CMD_ERR) ? FC_CMD_ERR : FC_TIMEOUT;
  assign attempts_inc = (attempts != 16'hFFFF) ? attempts + 16'd1 : attempts;

  always_comb begin
    phase_next       = phase;
    is_v2_next       = is_v2;
    is_high_cap_next = is_high_cap;
    rel_addr_next    = rel_addr;
    attempts_next    = attempts;
    if (accept) begin
      if (kind == KIND_START) begin
        phase_next       = PH_CMD0;
        is_v2_next       = 1'b0;
        is_high_cap_next = 1'b0;
        rel_addr_next    = 16'd0;
        attempts_next    = 16'd0;
      end else begin
        case (phase)
          PH_CMD0: phase_next = ok ? PH_CMD8 : PH_FAIL;
          PH_CMD8: begin
            attempts_next = 16'd0;
            if (ok) begin
              if (response[7:0] != check_pattern) begin
                phase_next = PH_FAIL;
              end else begin
                is_v2_next = 1'b1;
                phase_next = PH_CMD55;
              end
            end else if (status == ST_CMD_ERR) begin
              is_v2_next = 1'b0;
              phase_next = PH_CMD55;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_CMD55: phase_next = ok ? PH_ACMD41 : PH_FAIL;
          PH_ACMD41: begin
            if (!ok) begin
              phase_next = PH_FAIL;
            end else begin
              attempts_next = attempts_inc;
              if (response[31]) begin
                is_high_cap_next = response[30];
                phase_next       = PH_CMD2;
              end else if (attempts_inc >= retry_limit) begin
                phase_next = PH_FAIL;
              end else begin
                phase_next = PH_CMD55;
              end
            end
          end
          PH_CMD2: phase_next = ok ? PH_CMD3 : PH_FAIL;
          PH_CMD3: begin
            if (ok) begin
              rel_addr_next = response[31:16];
              phase_next    = PH_CLOCK;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_CLOCK: phase_next = ok ? PH_CMD7 : PH_FAIL;
          PH_CMD7:  phase_next = ok ? PH_DONE : PH_FAIL;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    n_res     = 2'd1;
    res_b_raw = make_result(ACT_CMD, CMD_APP, 32'd0, RT_R48, 1'b1, 1'b1, 20'd0, FC_NONE, 1'b1);
    res_a_raw = make_result(ACT_FAIL, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0, fail_status,
                            1'b1);
    if (kind == KIND_START) begin
      res_a_raw = make_result(ACT_CMD, CMD_GO_IDLE, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                              FC_NONE, 1'b1);
    end else begin
      case (phase)
        PH_CMD0: begin
          if (ok) begin
            res_a_raw = make_result(ACT_CMD, CMD_SEND_IF, {20'd0, CMD8_VHS, check_pattern},
                                    RT_R48, 1'b1, 1'b1, idle_pause_us, FC_NONE, 1'b1);
          end
        end
        PH_CMD8: begin
          if (ok) begin
            if (response[7:0] != check_pattern) begin
              res_a_raw = make_result(ACT_FAIL, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                                      FC_UNSUPPORTED, 1'b1);
            end else begin
              res_a_raw = res_b_raw;
            end
          end else if (status == ST_CMD_ERR) begin
            n_res     = 2'd2;
            res_a_raw = make_result(ACT_RESET, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                                    FC_NONE, 1'b0);
          end
        end
        PH_CMD55: begin
          if (ok) begin
            res_a_raw = make_result(ACT_CMD, CMD_SEND_OP, {1'b0, is_v2, 6'd0, voltage_window},
                                    RT_R48, 1'b0, 1'b0, 20'd0, FC_NONE, 1'b1);
          end
        end
        PH_ACMD41: begin
          if (ok) begin
            if (response[31]) begin
              res_a_raw = make_result(ACT_CMD, CMD_ALL_SEND_CID, 32'd0, RT_R136, 1'b1, 1'b0,
                                      20'd0, FC_NONE, 1'b1);
            end else if (attempts_inc >= retry_limit) begin
              res_a_raw = make_result(ACT_FAIL, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                                      FC_TIMEOUT, 1'b1);
            end else begin
              res_a_raw = make_result(ACT_CMD, CMD_APP, 32'd0, RT_R48, 1'b1, 1'b1,
                                      retry_pause_us, FC_NONE, 1'b1);
            end
          end
        end
        PH_CMD2: begin
          if (ok) begin
            res_a_raw = make_result(ACT_CMD, CMD_SEND_RCA, 32'd0, RT_R48, 1'b1, 1'b1, 20'd0,
                                    FC_NONE, 1'b1);
          end
        end
        PH_CMD3: begin
          if (ok) begin
            res_a_raw = make_result(ACT_CLOCK, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                                    FC_NONE, 1'b1);
          end
        end
        PH_CLOCK: begin
          if (ok) begin
            res_a_raw = make_result(ACT_CMD, CMD_SELECT, {rel_addr, 16'd0}, RT_R48B, 1'b1,
                                    1'b1, 20'd0, FC_NONE, 1'b1);
          end
        end
        PH_CMD7: begin
          if (ok) begin
            res_a_raw = make_result(ACT_DONE, 6'd0, 32'd0, RT_NONE, 1'b0, 1'b0, 20'd0,
                                    FC_NONE, 1'b1);
          end
        end
        default: n_res = 2'd0;
      endcase
    end

    res_a               = res_a_raw;
    res_a.card_address  = rel_addr_next;
    res_a.high_capacity = is_high_cap_next;
    res_a.version_two   = is_v2_next;
    res_b               = res_b_raw;
    res_b.card_address  = rel_addr_next;
    res_b.high_capacity = is_high_cap_next;
    res_b.version_two   = is_v2_next;
  end

  assign push_n     = accept ? n_res : 2'd0;
  assign pop        = out_valid && !out_stall;
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit    <= RESET_RETRY_LIMIT;
      voltage_window <= RESET_VOLTAGE_WINDOW;
      check_pattern  <= RESET_CHECK_PATTERN;
      idle_pause_us  <= RESET_IDLE_PAUSE;
      retry_pause_us <= RESET_RETRY_PAUSE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RETRY_LIMIT:    retry_limit    <= cfg_data[15:0];
        REG_VOLTAGE_WINDOW: voltage_window <= cfg_data;
        REG_CHECK_PATTERN:  check_pattern  <= cfg_data[7:0];
        REG_IDLE_PAUSE:     idle_pause_us  <= cfg_data[19:0];
        REG_RETRY_PAUSE:    retry_pause_us <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      is_v2       <= 1'b0;
      is_high_cap <= 1'b0;
      rel_addr    <= 16'd0;
      attempts    <= 16'd0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      phase       <= phase_next;
      is_v2       <= is_v2_next;
      is_high_cap <= is_high_cap_next;
      rel_addr    <= rel_addr_next;
      attempts    <= attempts_next;
      wr_ptr      <= wr_ptr + PTR_W'(push_n);
      rd_ptr      <= rd_ptr + PTR_W'(pop);
      count       <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res_a;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= res_b;
    end
  end

  assign in_stall      = (count > STALL_LEVEL);
  assign out_valid     = (count != '0);
  assign action        = queue[rd_ptr].action;
  assign cmd_index     = queue[rd_ptr].cmd_index;
  assign argument      = queue[rd_ptr].argument;
  assign resp_type     = queue[rd_ptr].resp_type;
  assign check_crc     = queue[rd_ptr].check_crc;
  assign check_index   = queue[rd_ptr].check_index;
  assign pause_us      = queue[rd_ptr].pause_us;
  assign fail_code     = queue[rd_ptr].fail_code;
  assign card_address  = queue[rd_ptr].card_address;
  assign high_capacity = queue[rd_ptr].high_capacity;
  assign version_two   = queue[rd_ptr].version_two;
  assign last          = queue[rd_ptr].last;

endmodule

// File: hdl/sdci_checker.sv
// Port-level checker for the SD card bring-up sequencer and its bind.
// Depends on sdci_pkg and attaches to sd_card_init_sequencer_unit.
module sdci_checker
  import sdci_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  action,
  input logic [5:0]  cmd_index,
  input logic [31:0] argument,
  input logic [1:0]  resp_type,
  input logic [1:0]  fail_code,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("Result offered right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(argument))
    else $error("Stalled result item changed.");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("Second result of an item did not follow the first.");

  a_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_CMD) |->
      (cmd_index == 6'd0) && (argument == 32'd0) && (resp_type == RT_NONE))
    else $error("Command fields set on a non-command result item.");

  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_FAIL) |-> (fail_code == FC_NONE))
    else $error("Fail code set on a result item that is not a failure.");

endmodule

bind sd_card_init_sequencer_unit sdci_checker u_sdci_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .action    (action),
  .cmd_index (cmd_index),
  .argument  (argument),
  .resp_type (resp_type),
  .fail_code (fail_code),
  .last      (last)
);

// File: tb/sd_card_init_sequencer_unit_tb.sv
// Self-checking testbench for the SD card bring-up sequencer.
// A built-in predictor tracks phase, card state and registers and checks every result item.
// Depends on sdci_pkg and sd_card_init_sequencer_unit.
module sd_card_init_sequencer_unit_tb
  import sdci_pkg::*;
();

  localparam logic       KIND_OUTCOME = 1'b1;
  localparam logic [1:0] ST_TIMEOUT   = 2'd2;
  localparam logic [1:0] ST_UNUSED    = 2'd3;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE      = 4;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [1:0]  status = '0;
  logic [31:0] response = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic [1:0]  resp_type;
  logic        check_crc;
  logic        check_index;
  logic [19:0] pause_us;
  logic [1:0]  fail_code;
  logic [15:0] card_address;
  logic        high_capacity;
  logic        version_two;
  logic        last;

  sd_card_init_sequencer_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .status(status), .response(response),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .cmd_index(cmd_index), .argument(argument),
    .resp_type(resp_type), .check_crc(check_crc), .check_index(check_index),
    .pause_us(pause_us), .fail_code(fail_code), .card_address(card_address),
    .high_capacity(high_capacity), .version_two(version_two), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state and register copies.
  phase_t      seq_phase = PH_IDLE;
  logic        card_v2 = 1'b0;
  logic        card_hc = 1'b0;
  logic [15:0] card_rca = '0;
  logic [15:0] acmd41_tries = '0;
  logic [15:0] limit_cfg = RESET_RETRY_LIMIT;
  logic [23:0] window_cfg = RESET_VOLTAGE_WINDOW;
  logic [7:0]  pattern_cfg = RESET_CHECK_PATTERN;
  logic [19:0] idle_pause_cfg = RESET_IDLE_PAUSE;
  logic [19:0] retry_pause_cfg = RESET_RETRY_PAUSE;

  result_t pending_actions[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bringups_done = 0;
  int unsigned bringups_failed = 0;
  int unsigned settings_applied = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;

  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  flow_t       flow_mode = FLOW_FREE;
  int unsigned flow_left = 0;

  task automatic queue_action(input action_t act, input logic [5:0] cmd,
                              input logic [31:0] arg, input logic [1:0] rt,
                              input logic crc, input logic idx, input logic [19:0] pause,
                              input logic [1:0] fc, input logic lst);
    result_t r;
    r.action        = act;
    r.cmd_index     = cmd;
    r.argument      = arg;
    r.resp_type     = rt;
    r.check_crc     = crc;
    r.check_index   = idx;
    r.pause_us      = pause;
    r.fail_code     = fc;
    r.card_address  = card_rca;
    r.high_capacity = card_hc;
    r.version_two   = card_v2;
    r.last          = lst;
    pending_actions.push_back(r);
  endtask

  task automatic abort_bringup(input logic [1:0] fc);
    seq_phase = PH_FAIL;
    queue_action(ACT_FAIL, '0, '0, RT_NONE, 1'b0, 1'b0, '0, fc, 1'b1);
  endtask

  task automatic request_app_cmd(input logic [19:0] pause);
    seq_phase = PH_CMD55;
    queue_action(ACT_CMD, CMD_APP, '0, RT_R48, 1'b1, 1'b1, pause, FC_NONE, 1'b1);
  endtask

  task automatic advance_sequencer(input logic k, input logic [1:0] st,
                                   input logic [31:0] rsp);
    logic [1:0] err_code;
    logic       failed;
    err_code = (st == ST_CMD_ERR) ? FC_CMD_ERR : FC_TIMEOUT;
    failed   = (st != ST_OK);
    if (k == KIND_START) begin
      card_v2      = 1'b0;
      card_hc      = 1'b0;
      card_rca     = '0;
      acmd41_tries = '0;
      seq_phase    = PH_CMD0;
      queue_action(ACT_CMD, CMD_GO_IDLE, '0, RT_NONE, 1'b0, 1'b0, '0, FC_NONE, 1'b1);
      return;
    end
    case (seq_phase)
      PH_CMD0: begin
        if (failed) abort_bringup(err_code);
        else begin
          seq_phase = PH_CMD8;
          queue_action(ACT_CMD, CMD_SEND_IF, {20'd0, CMD8_VHS, pattern_cfg}, RT_R48,
                       1'b1, 1'b1, idle_pause_cfg, FC_NONE, 1'b1);
        end
      end
      PH_CMD8: begin
        acmd41_tries = '0;
        if (st == ST_OK) begin
          if (rsp[7:0] != pattern_cfg) abort_bringup(FC_UNSUPPORTED);
          else begin
            card_v2 = 1'b1;
            request_app_cmd('0);
          end
        end else if (st == ST_CMD_ERR) begin
          card_v2 = 1'b0;
          queue_action(ACT_RESET, '0, '0, RT_NONE, 1'b0, 1'b0, '0, FC_NONE, 1'b0);
          request_app_cmd('0);
        end else abort_bringup(err_code);
      end
      PH_CMD55: begin
        if (failed) abort_bringup(err_code);
        else begin
          seq_phase = PH_ACMD41;
          queue_action(ACT_CMD, CMD_SEND_OP, {1'b0, card_v2, 6'd0, window_cfg}, RT_R48,
                       1'b0, 1'b0, '0, FC_NONE, 1'b1);
        end
      end
      PH_ACMD41: begin
        if (failed) abort_bringup(err_code);
        else begin
          if (acmd41_tries != 16'hFFFF) acmd41_tries = acmd41_tries + 16'd1;
          if (rsp[31]) begin
            card_hc   = rsp[30];
            seq_phase = PH_CMD2;
            queue_action(ACT_CMD, CMD_ALL_SEND_CID, '0, RT_R136, 1'b1, 1'b0, '0,
                         FC_NONE, 1'b1);
          end else if (acmd41_tries >= limit_cfg) abort_bringup(FC_TIMEOUT);
          else request_app_cmd(retry_pause_cfg);
        end
      end
      PH_CMD2: begin
        if (failed) abort_bringup(err_code);
        else begin
          seq_phase = PH_CMD3;
          queue_action(ACT_CMD, CMD_SEND_RCA, '0, RT_R48, 1'b1, 1'b1, '0, FC_NONE, 1'b1);
        end
      end
      PH_CMD3: begin
        if (failed) abort_bringup(err_code);
        else begin
          card_rca  = rsp[31:16];
          seq_phase = PH_CLOCK;
          queue_action(ACT_CLOCK, '0, '0, RT_NONE, 1'b0, 1'b0, '0, FC_NONE, 1'b1);
        end
      end
      PH_CLOCK: begin
        if (failed) abort_bringup(err_code);
        else begin
          seq_phase = PH_CMD7;
          queue_action(ACT_CMD, CMD_SELECT, {card_rca, 16'd0}, RT_R48B, 1'b1, 1'b1, '0,
                       FC_NONE, 1'b1);
        end
      end
      PH_CMD7: begin
        if (failed) abort_bringup(err_code);
        else begin
          seq_phase = PH_DONE;
          queue_action(ACT_DONE, '0, '0, RT_NONE, 1'b0, 1'b0, '0, FC_NONE, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %0h, expected %0h (result %0d)",
               what, got, want, results_checked);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : take_result
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("unexpected result item", 32'(action), '0);
      end else begin
        want = pending_actions.pop_front();
        check_field("action", 32'(action), 32'(want.action));
        check_field("cmd_index", 32'(cmd_index), 32'(want.cmd_index));
        check_field("argument", argument, want.argument);
        check_field("resp_type", 32'(resp_type), 32'(want.resp_type));
        check_field("check_crc", 32'(check_crc), 32'(want.check_crc));
        check_field("check_index", 32'(check_index), 32'(want.check_index));
        check_field("pause_us", 32'(pause_us), 32'(want.pause_us));
        check_field("fail_code", 32'(fail_code), 32'(want.fail_code));
        check_field("card_address", 32'(card_address), 32'(want.card_address));
        check_field("high_capacity", 32'(high_capacity), 32'(want.high_capacity));
        check_field("version_two", 32'(version_two), 32'(want.version_two));
        check_field("last", 32'(last), 32'(want.last));
        results_checked++;
        if (action == ACT_DONE) bringups_done++;
        if (action == ACT_FAIL) bringups_failed++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode <= flow_t'($urandom_range(0, 3));
        flow_left <= $urandom_range(20, 200);
      end else begin
        flow_left <= flow_left - 1;
      end
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:    out_stall <= (flow_left[1:0] == 2'd0);
      endcase
    end
  end

  task automatic pace_sender();
    int unsigned gap;
    if (steady) return;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic k, input logic [1:0] st, input logic [31:0] rsp);
    in_valid <= 1'b1;
    kind     <= k;
    status   <= st;
    response <= rsp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(k, st, rsp);
    items_sent++;
    pace_sender();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_RETRY_LIMIT:    limit_cfg       = value[15:0];
      REG_VOLTAGE_WINDOW: window_cfg      = value;
      REG_CHECK_PATTERN:  pattern_cfg     = value[7:0];
      REG_IDLE_PAUSE:     idle_pause_cfg  = value[19:0];
      REG_RETRY_PAUSE:    retry_pause_cfg = value[19:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] lim, input logic [23:0] window,
                            input logic [23:0] pattern, input logic [23:0] idle_pause,
                            input logic [23:0] retry_pause);
    wait_for_results();
    put_reg(REG_RETRY_LIMIT, lim);
    put_reg(REG_VOLTAGE_WINDOW, window);
    put_reg(REG_CHECK_PATTERN, pattern);
    put_reg(REG_IDLE_PAUSE, idle_pause);
    put_reg(REG_RETRY_PAUSE, retry_pause);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Mostly well-formed bring-ups with random content, some errors and restarts,
  // and a few outcomes that arrive when nothing was requested.
  task automatic random_item(output bit counted);
    logic        k;
    logic [1:0]  st;
    logic [31:0] rsp;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    rsp  = $urandom;
    st   = ST_OK;
    k    = KIND_OUTCOME;
    if (seq_phase inside {PH_IDLE, PH_DONE, PH_FAIL}) begin
      if (roll < 85) k = KIND_START;
      st = 2'($urandom_range(0, 3));
    end else if (roll < 3) begin
      k  = KIND_START;
      st = 2'($urandom_range(0, 3));
    end else if (roll < 8) begin
      st = 2'($urandom_range(1, 3));
    end else if (seq_phase == PH_CMD8 && roll < 22) begin
      st = ST_CMD_ERR;
    end else if (seq_phase == PH_CMD8 && roll < 92) begin
      rsp[7:0] = pattern_cfg;
    end else if (seq_phase == PH_ACMD41) begin
      rsp[31] = ($urandom_range(0, 9) < 4);
    end
    counted = !(k == KIND_OUTCOME && seq_phase inside {PH_IDLE, PH_DONE, PH_FAIL});
    send_item(k, st, rsp);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned done_n;
    bit          counted;
    done_n = 0;
    while (done_n < n) begin
      random_item(counted);
      if (counted) done_n++;
    end
  endtask

  task automatic test_bringup_v2();
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_START, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'hFFFF_FFAA);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h7FFF_FFFF);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'hC0FF_8000);
    send_item(KIND_OUTCOME, ST_OK, 32'hFFFF_FFFF);
    send_item(KIND_OUTCOME, ST_OK, 32'hFFFF_0000);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_bringup_v1();
    send_item(KIND_START, ST_UNUSED, 32'hFFFF_FFFF);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_CMD_ERR, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h8000_0000);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0000_FFFF);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
  endtask

  task automatic test_failures();
    send_item(KIND_START, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_UNUSED, 32'h0);
    send_item(KIND_START, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0000_0055);
    send_item(KIND_START, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_START, ST_TIMEOUT, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_TIMEOUT, 32'h0);
  endtask

  // A zero retry limit behaves like one: the first not-ready reply ends the bring-up.
  task automatic test_zero_retry_limit();
    set_config(24'h0, 24'h00_1234, 24'h3C, 24'h0, 24'h0);
    send_item(KIND_START, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0000_003C);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
  endtask

  task automatic test_backpressure();
    wait_for_results();
    steady = 1'b1;
    hold_asks++;
    repeat (4) send_item(KIND_START, ST_OK, $urandom);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_CMD_ERR, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'h0);
    send_item(KIND_OUTCOME, ST_OK, 32'hFFFF_FFFF);
    run_random(40);
    steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_default();
    run_random(150);
  endtask

  task automatic test_random_settings();
    set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    run_random(150);
    set_config(24'h00_0001, 24'h0, 24'h0, 24'h0, 24'h0);
    run_random(150);
    repeat (2) begin
      set_config(24'($urandom_range(1, 6)), 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom));
      run_random(130);
    end
    set_config({8'hA5, RESET_RETRY_LIMIT}, RESET_VOLTAGE_WINDOW, {16'h5A5A, RESET_CHECK_PATTERN},
               {4'hF, RESET_IDLE_PAUSE}, {4'hF, RESET_RETRY_PAUSE});
    @(posedge clk);
    put_reg(REG_UNUSED, 24'hFF_FFFF);
    cfg_write <= 1'b0;
    run_random(40);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_bringup_v2();
    test_bringup_v1();
    test_failures();
    test_random_default();
    test_backpressure();
    test_zero_retry_limit();
    test_random_settings();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("run covered %0d items and %0d checked result items: %0d bring-ups done, %0d failed",
             items_sent, results_checked, bringups_done, bringups_failed);
    $display("register settings applied: %0d, receiver hold-offs: %0d",
             settings_applied, hold_asks);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
